// ===== design/clsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsp_pkg: shared types and constants of the combined LCG shuffle generator
// Holds the generator constants, the interface widths and the command word
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package clsp_pkg;

    // Width of one generator state word and of one output value.
    localparam int VALUE_W = 31;

    // Interface widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;

    // Register index as decoded from paddr[2].
    localparam logic REG_SEED = 1'b0;

    // Generator one: x * 40014 mod (2^31 - 85).
    localparam logic [15:0]        MUL_ONE  = 16'd40014;
    localparam logic [VALUE_W-1:0] MOD_ONE  = 31'd2147483563;
    localparam logic [7:0]         FOLD_ONE = 8'd85;

    // Generator two: x * 40692 mod (2^31 - 249).
    localparam logic [15:0]        MUL_TWO  = 16'd40692;
    localparam logic [VALUE_W-1:0] MOD_TWO  = 31'd2147483399;
    localparam logic [7:0]         FOLD_TWO = 8'd249;

    // Output range is 1..WRAP_SPAN.
    localparam logic [31:0] WRAP_SPAN = 32'd2147483562;

    // Reset value of generator two and the saturated seed magnitude.
    localparam logic [VALUE_W-1:0] GEN_TWO_RESET = 31'd123456789;
    localparam logic [VALUE_W-1:0] SEED_MAX      = 31'h7FFF_FFFF;

    // Selects which generator a modular multiply works on.
    typedef enum logic
    {
        GEN_SEL_ONE,
        GEN_SEL_TWO
    } gen_sel_t;

    // Command word from the controller to the datapath.
    typedef struct packed
    {
        logic     issue;       // start a modular multiply step
        gen_sel_t issue_sel;   // generator for that step
        logic     slot_mul;    // start the slot reciprocal multiply
        logic     slot_read;   // read the shuffle table at the slot
        logic     init_load;   // load both generators from the seed
        logic     init_store;  // write the returning step into the table
        logic     init_last;   // last fill step: it also becomes last_out
        logic     finish;      // form the result, refill the slot
    } clsp_cmd_t;

endpackage

// ===== design/clsp_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsp_modmul: pipelined modular multiplier shared by both generators
// Three stages: multiply by the generator constant, fold the bits above
// 2^31 back in (2^31 is congruent to 85 or 249), then one conditional
// subtract of the modulus. The generator select travels with the word.
// ----------------------------------------------------------------------------
module clsp_modmul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  clsp_pkg::gen_sel_t            in_sel,
    input  logic [clsp_pkg::VALUE_W-1:0]  in_x,
    output logic                          out_valid,
    output clsp_pkg::gen_sel_t            out_sel,
    output logic [clsp_pkg::VALUE_W-1:0]  out_value
);
    import clsp_pkg::*;

    localparam int PROD_W = VALUE_W + 16;
    localparam int FOLD_W = VALUE_W + 1;

    logic                s1_valid_reg;
    gen_sel_t            s1_sel_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic [PROD_W-1:0]   s1_prod_next;
    logic                s2_valid_reg;
    gen_sel_t            s2_sel_reg;
    logic [FOLD_W-1:0]   s2_fold_reg;
    logic [FOLD_W-1:0]   s2_fold_next;
    logic [15:0]         mul_k;
    logic [7:0]          fold_k;
    logic [23:0]         fold_term;
    logic [VALUE_W-1:0]  mod_k;

    // Stage one: product of the state word and the generator multiplier.
    always_comb
    begin
        mul_k        = (in_sel == GEN_SEL_ONE) ? MUL_ONE : MUL_TWO;
        s1_prod_next = PROD_W'(in_x) * PROD_W'(mul_k);
    end

    // Stage two: high part times (2^31 mod m) added to the low part.
    always_comb
    begin
        fold_k       = (s1_sel_reg == GEN_SEL_ONE) ? FOLD_ONE : FOLD_TWO;
        fold_term    = 24'(s1_prod_reg[PROD_W-1:VALUE_W]) * 24'(fold_k);
        s2_fold_next = FOLD_W'(s1_prod_reg[VALUE_W-1:0]) + FOLD_W'(fold_term);
    end

    // Stage three: the folded sum is below twice the modulus.
    always_comb
    begin
        mod_k = (s2_sel_reg == GEN_SEL_ONE) ? MOD_ONE : MOD_TWO;
        if (s2_fold_reg >= FOLD_W'(mod_k))
        begin
            out_value = VALUE_W'(s2_fold_reg - FOLD_W'(mod_k));
        end
        else
        begin
            out_value = s2_fold_reg[VALUE_W-1:0];
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_sel   = s2_sel_reg;

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        s1_sel_reg  <= in_sel;
        s1_prod_reg <= s1_prod_next;
        s2_sel_reg  <= s1_sel_reg;
        s2_fold_reg <= s2_fold_next;
    end

endmodule

// ===== design/clsp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsp_datapath: generator state, shuffle table and result logic
// Holds both generator words, the last output, the shuffle table memory,
// the slot divider (reciprocal multiply) and the output value register.
// ----------------------------------------------------------------------------
module clsp_datapath
#(
    parameter int TABLE_DEPTH = 32,
    parameter int CNT_W       = 6
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [31:0]                   seed,
    input  clsp_pkg::clsp_cmd_t           cmd,
    input  logic [CNT_W-1:0]              init_idx,
    output logic [clsp_pkg::VALUE_W-1:0]  value,
    output logic                          last_zero
);
    import clsp_pkg::*;

    // Slot = last_out / SLOT_DIV, done as a multiply by a rounded-up
    // reciprocal; the error term stays below one for any 31-bit input.
    localparam longint SLOT_DIV = 1 + (2147483563 - 1) / TABLE_DEPTH;
    localparam int     RECIP_K  = VALUE_W + $clog2(SLOT_DIV);
    localparam longint RECIP    = ((64'sd1 <<< RECIP_K) + SLOT_DIV - 1) / SLOT_DIV;
    localparam logic [32:0] RECIP_C = 33'(RECIP);
    localparam int     QW       = $clog2(TABLE_DEPTH + 1);
    localparam int     AW       = $clog2(TABLE_DEPTH);

    logic [VALUE_W-1:0]  gen_one_reg;
    logic [VALUE_W-1:0]  gen_one_next;
    logic [VALUE_W-1:0]  gen_two_reg;
    logic [VALUE_W-1:0]  gen_two_next;
    logic [VALUE_W-1:0]  last_out_reg;
    logic [VALUE_W-1:0]  last_out_next;
    logic [63:0]         slot_prod_reg;
    logic [AW-1:0]       slot_reg;
    logic [VALUE_W-1:0]  picked_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [VALUE_W-1:0]  shuf_mem [TABLE_DEPTH];

    logic [31:0]         seed_abs;
    logic [VALUE_W-1:0]  seed_mag;
    logic                mm_valid;
    gen_sel_t            mm_sel;
    logic [VALUE_W-1:0]  mm_value;
    logic [VALUE_W-1:0]  mm_x;
    logic [QW-1:0]       slot_quot;
    logic [AW-1:0]       slot;
    logic [31:0]         diff_direct;
    logic [31:0]         diff_wrap;
    logic [VALUE_W-1:0]  result;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [VALUE_W-1:0]  mem_wdata;

    // Seed magnitude: negate negatives, saturate 2^31, replace zero by one.
    always_comb
    begin
        seed_abs = seed[31] ? (~seed + 32'd1) : seed;
        if (seed_abs[31])
        begin
            seed_mag = SEED_MAX;
        end
        else if (seed_abs[VALUE_W-1:0] == '0)
        begin
            seed_mag = VALUE_W'(1);
        end
        else
        begin
            seed_mag = seed_abs[VALUE_W-1:0];
        end
    end

    // Shared modular multiplier for both generators.
    assign mm_x = (cmd.issue_sel == GEN_SEL_ONE) ? gen_one_reg : gen_two_reg;

    clsp_modmul u_modmul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.issue),
        .in_sel    (cmd.issue_sel),
        .in_x      (mm_x),
        .out_valid (mm_valid),
        .out_sel   (mm_sel),
        .out_value (mm_value)
    );

    // Slot index from the registered reciprocal product, clamped to the table.
    always_comb
    begin
        slot_quot = QW'(slot_prod_reg >> RECIP_K);
        if (slot_quot >= QW'(TABLE_DEPTH))
        begin
            slot = AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            slot = slot_quot[AW-1:0];
        end
    end

    // Picked entry minus generator two, wrapped into 1..WRAP_SPAN.
    always_comb
    begin
        diff_direct = {1'b0, picked_reg} - {1'b0, gen_two_reg};
        diff_wrap   = {1'b0, picked_reg} + WRAP_SPAN - {1'b0, gen_two_reg};
        if (picked_reg > gen_two_reg)
        begin
            result = diff_direct[VALUE_W-1:0];
        end
        else
        begin
            result = diff_wrap[VALUE_W-1:0];
        end
    end

    // Next values of the generator words and of the last output.
    always_comb
    begin
        gen_one_next  = gen_one_reg;
        gen_two_next  = gen_two_reg;
        last_out_next = last_out_reg;
        if (cmd.init_load)
        begin
            gen_one_next = seed_mag;
            gen_two_next = seed_mag;
        end
        else if (mm_valid)
        begin
            if (mm_sel == GEN_SEL_ONE)
            begin
                gen_one_next = mm_value;
            end
            else
            begin
                gen_two_next = mm_value;
            end
        end
        if (cmd.init_last)
        begin
            last_out_next = mm_value;
        end
        else if (cmd.finish)
        begin
            last_out_next = result;
        end
    end

    // Table write port: fill during initialization, refill after a draw.
    always_comb
    begin
        mem_we    = cmd.init_store || cmd.finish;
        mem_waddr = cmd.init_store ? init_idx[AW-1:0] : slot_reg;
        mem_wdata = cmd.init_store ? mm_value : gen_one_reg;
    end

    // Generator and last-output state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_one_reg  <= '0;
            gen_two_reg  <= GEN_TWO_RESET;
            last_out_reg <= '0;
        end
        else
        begin
            gen_one_reg  <= gen_one_next;
            gen_two_reg  <= gen_two_next;
            last_out_reg <= last_out_next;
        end
    end

    // Reciprocal product, slot and output value.
    always_ff @(posedge clk)
    begin
        if (cmd.slot_mul)
        begin
            slot_prod_reg <= {33'd0, last_out_reg} * {31'd0, RECIP_C};
        end
        if (cmd.slot_read)
        begin
            slot_reg <= slot;
        end
        if (cmd.finish)
        begin
            value_reg <= result;
        end
    end

    // Shuffle table memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shuf_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.slot_read)
        begin
            picked_reg <= shuf_mem[slot];
        end
    end

    assign value     = value_reg;
    assign last_zero = (last_out_reg == '0);

endmodule

// ===== design/clsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsp_ctrl: sequencer of the combined LCG shuffle generator
// Accepts draw requests, runs the initialization sweep when needed, steps
// the datapath through a draw and owns the output valid flag.
// ----------------------------------------------------------------------------
module clsp_ctrl
#(
    parameter int TABLE_DEPTH  = 32,
    parameter int WARMUP_STEPS = 8,
    parameter int CNT_W        = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 reseed,
    input  logic                 m_tready,
    input  logic                 last_zero,
    output logic                 s_tready,
    output logic                 m_tvalid,
    output clsp_pkg::clsp_cmd_t  cmd,
    output logic [CNT_W-1:0]     init_idx
);
    import clsp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(TABLE_DEPTH + WARMUP_STEPS - 1);

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_INIT_LOAD,
        ST_INIT_ISSUE,
        ST_INIT_W1,
        ST_INIT_W2,
        ST_DRAW_START,
        ST_DRAW_ISSUE,
        ST_DRAW_W1,
        ST_DRAW_W2,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              accept;
    logic              fill_step;

    assign accept    = s_tvalid && (state_reg == ST_IDLE);
    assign fill_step = ({{(32-CNT_W){1'b0}}, cnt_reg} < 32'(TABLE_DEPTH));

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (reseed || last_zero)
                    begin
                        state_next = ST_INIT_LOAD;
                    end
                    else
                    begin
                        // Start generator two and the slot divide right away.
                        cmd.issue     = 1'b1;
                        cmd.issue_sel = GEN_SEL_TWO;
                        cmd.slot_mul  = 1'b1;
                        state_next    = ST_DRAW_ISSUE;
                    end
                end
            end
            ST_INIT_LOAD:
            begin
                cmd.init_load = 1'b1;
                cnt_next      = CNT_START;
                state_next    = ST_INIT_ISSUE;
            end
            ST_INIT_ISSUE:
            begin
                cmd.issue     = 1'b1;
                cmd.issue_sel = GEN_SEL_ONE;
                state_next    = ST_INIT_W1;
            end
            ST_INIT_W1:
            begin
                state_next = ST_INIT_W2;
            end
            ST_INIT_W2:
            begin
                // The step returns now; warm-up steps are not stored.
                cmd.init_store = fill_step;
                if (cnt_reg == '0)
                begin
                    cmd.init_last = 1'b1;
                    state_next    = ST_DRAW_START;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_INIT_ISSUE;
                end
            end
            ST_DRAW_START:
            begin
                cmd.issue     = 1'b1;
                cmd.issue_sel = GEN_SEL_TWO;
                cmd.slot_mul  = 1'b1;
                state_next    = ST_DRAW_ISSUE;
            end
            ST_DRAW_ISSUE:
            begin
                cmd.issue     = 1'b1;
                cmd.issue_sel = GEN_SEL_ONE;
                cmd.slot_read = 1'b1;
                state_next    = ST_DRAW_W1;
            end
            ST_DRAW_W1:
            begin
                state_next = ST_DRAW_W2;
            end
            ST_DRAW_W2:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Commit only when the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign init_idx = cnt_reg;

endmodule

// ===== design/combined_lcg_shuffle_prng_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_prng_core: combined LCG with a shuffle table
// Two multiplicative congruential generators combined through a
// Bays-Durham shuffle table, with an APB seed register.
//
//   Channel   Dir   Contents                          Handshake
//   s_*       in    draw request: reseed flag         tvalid / tready
//   m_*       out   random value 1..2147483562        tvalid / tready
//   APB       in    seed register at address 0        psel/penable, pready=1
//
// A plain draw starts generator two and the slot multiply on acceptance,
// then generator one and the registered table read, and loads the output
// register once the pipelined modular multiplier shared by both generators
// has returned both steps; the next request is taken only after that. An
// initialization runs TABLE_DEPTH+WARMUP_STEPS generator-one steps, each
// waiting for the one before it. Reset clears the control state; the first
// draw initializes. A new request is accepted while a finished value waits
// on m_*; a stalled output holds the next draw in its final step.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_prng_core
#(
    parameter int TABLE_DEPTH  = 32,
    parameter int WARMUP_STEPS = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: [0] reseed, [7:1] zero
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [clsp_pkg::IN_TDATA_W-1:0]    s_tdata,
    // m_tdata: [30:0] value, [31] zero
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [clsp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [clsp_pkg::PADDR_W-1:0]       paddr,
    input  logic [clsp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [clsp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import clsp_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + WARMUP_STEPS);

    logic [APB_DATA_W-1:0]  seed_reg;
    logic                   seed_we;
    clsp_cmd_t              cmd;
    logic [CNT_W-1:0]       init_idx;
    logic                   last_zero;
    logic [VALUE_W-1:0]     value;

    // Seed register on the APB port.
    assign pready  = 1'b1;
    assign seed_we = psel && penable && pwrite && pready && (paddr[2] == REG_SEED);
    assign prdata  = (paddr[2] == REG_SEED) ? seed_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd1;
        end
        else if (seed_we)
        begin
            seed_reg <= pwdata;
        end
    end

    clsp_ctrl
    #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .WARMUP_STEPS (WARMUP_STEPS),
        .CNT_W        (CNT_W)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .reseed    (s_tdata[0]),
        .m_tready  (m_tready),
        .last_zero (last_zero),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .cmd       (cmd),
        .init_idx  (init_idx)
    );

    clsp_datapath
    #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CNT_W       (CNT_W)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed_reg),
        .cmd       (cmd),
        .init_idx  (init_idx),
        .value     (value),
        .last_zero (last_zero)
    );

    assign m_tdata = {1'b0, value};

endmodule

// ===== design/clsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsp_checker: port-level checks for the combined LCG shuffle generator
// Watches the stream and APB ports of the core; attached by bind.
// ----------------------------------------------------------------------------
module clsp_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [clsp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                               pready
);
    import clsp_pkg::*;

    // A stalled output word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

    // Every value lies in 1..WRAP_SPAN with the pad bit clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[31] && (m_tdata[30:0] != 31'd0)
                     && ({1'b0, m_tdata[30:0]} <= WRAP_SPAN))
    else $error("output value out of range");

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while a draw is running");

    // A new word appears only as a draw ends, when no request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
    else $error("output word appeared without a finished draw");

    // The configuration port never waits.
    assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind combined_lcg_shuffle_prng_core clsp_checker u_clsp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
